[design/timed_counting_semaphore_core_assert.svh]
// Assertion macros shared by the semaphore core
`ifndef TIMED_COUNTING_SEMAPHORE_CORE_ASSERT_SVH
`define TIMED_COUNTING_SEMAPHORE_CORE_ASSERT_SVH

// Check that b holds in the same cycle as a
`define TCS_ASSERT_IMPL(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("tcs assertion failed");

// Check that b holds in the cycle after a
`define TCS_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("tcs assertion failed");

`endif

[design/tcs_pkg.sv]
`default_nettype none
package tcs_pkg;
	localparam int TASK_W    = 8;
	localparam int TIMEOUT_W = 16;
	localparam int COUNT_W   = 16;
	localparam int INIT_W    = 15;
	localparam int FUNC_W    = 2;
	localparam int OC_W      = 3;

	localparam int MAX_TIMED_DEF    = 16;
	localparam int MAX_UNTIMED_DEF  = 16;
	localparam int TASK_ID_BITS_DEF = 8;

	localparam logic [INIT_W-1:0] INIT_COUNT_RST = 15'd1;

	localparam logic [FUNC_W-1:0] FUNC_WAIT   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SIGNAL = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd3;

	localparam logic [OC_W-1:0] OC_GRANTED = 3'd0;
	localparam logic [OC_W-1:0] OC_BLOCKED = 3'd1;
	localparam logic [OC_W-1:0] OC_WOKEN   = 3'd2;
	localparam logic [OC_W-1:0] OC_TIMEOUT = 3'd3;
	localparam logic [OC_W-1:0] OC_FLUSHED = 3'd4;
	localparam logic [OC_W-1:0] OC_NONE    = 3'd5;
	localparam logic [OC_W-1:0] OC_REFUSED = 3'd6;

	typedef struct packed {
		logic [FUNC_W-1:0]    func;
		logic [TASK_W-1:0]    task_id;
		logic [TIMEOUT_W-1:0] timeout;
	} op_t;
endpackage
`default_nettype wire

[design/timed_counting_semaphore_core.sv]
// Timed counting semaphore.
// Input stream s_axis: tuser carries the operation (wait, signal, tick, flush),
// tdata the task id and the timeout in ticks (0 waits without limit).
// Output stream m_axis: one or more results per operation, tdata the task,
// tuser the outcome code, tlast marks the final result of an operation.
// cfg_valid/cfg_data load the initial count used at flush; write while idle.
// Operations run one at a time behind a two-entry input queue, so the input
// side stays open while the engine works or the output stalls, until the
// queue holds two operations.
// Grant, signal, untimed wait, and tick or flush with nothing to release give
// their single result from the execute state after the idle state takes the
// operation; the engine takes the next operation only once that is done.
// A timed wait walks the delta list, one entry per cycle, before its result.
// Tick and flush that release waiters give one result per cycle while the
// output register is free.
// Each result holds in the output register until m_axis_tready takes it; the
// engine writes no new result while the output register is full.
// Reset empties both waiter lists and the queue and loads count with 1 and
// the initial count register with 1; no clearing pass is needed.
`default_nettype none
module timed_counting_semaphore_core #(
	parameter int MAX_TIMED    = tcs_pkg::MAX_TIMED_DEF,
	parameter int MAX_UNTIMED  = tcs_pkg::MAX_UNTIMED_DEF,
	parameter int TASK_ID_BITS = tcs_pkg::TASK_ID_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [14:0] cfg_data,       // initial_count
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // task_id[7:0], timeout[23:8]
	input  wire logic [1:0]  s_axis_tuser,   // func[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // released_task[7:0]
	output logic [2:0]       m_axis_tuser,   // outcome[2:0]
	output logic             m_axis_tlast
);
	logic [tcs_pkg::INIT_W-1:0] init_q;
	logic                       op_valid, op_pop;
	tcs_pkg::op_t               op;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= tcs_pkg::INIT_COUNT_RST;
		end else if (cfg_valid) begin
			init_q <= cfg_data;
		end
	end

	tcs_front #(
		.TASK_ID_BITS(TASK_ID_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_func   (s_axis_tuser),
		.in_task   (s_axis_tdata[7:0]),
		.in_timeout(s_axis_tdata[23:8]),
		.op_valid  (op_valid),
		.op_pop    (op_pop),
		.op        (op)
	);

	tcs_back #(
		.MAX_TIMED  (MAX_TIMED),
		.MAX_UNTIMED(MAX_UNTIMED)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.init_count (init_q),
		.op_valid   (op_valid),
		.op_pop     (op_pop),
		.op         (op),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res_task   (m_axis_tdata),
		.res_outcome(m_axis_tuser),
		.res_last   (m_axis_tlast)
	);
endmodule
`default_nettype wire

[design/tcs_front.sv]
`default_nettype none
module tcs_front #(
	parameter int TASK_ID_BITS = tcs_pkg::TASK_ID_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [tcs_pkg::FUNC_W-1:0]    in_func,
	input  wire logic [tcs_pkg::TASK_W-1:0]    in_task,
	input  wire logic [tcs_pkg::TIMEOUT_W-1:0] in_timeout,
	output logic                               op_valid,
	input  wire logic                          op_pop,
	output tcs_pkg::op_t                       op
);
	localparam logic [tcs_pkg::TASK_W-1:0] TASK_MASK = (TASK_ID_BITS >= tcs_pkg::TASK_W) ?
		{tcs_pkg::TASK_W{1'b1}} : tcs_pkg::TASK_W'((1 << TASK_ID_BITS) - 1);

	tcs_pkg::op_t buf_q [2];
	logic         wr_q, rd_q;
	logic [1:0]   cnt_q;
	logic         push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign op_valid = (cnt_q != 2'd0);
	assign op       = buf_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = op_pop && op_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// mask the task id at entry so the back end never sees stray bits
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q].func    <= in_func;
			buf_q[wr_q].task_id <= in_task & TASK_MASK;
			buf_q[wr_q].timeout <= in_timeout;
		end
	end
endmodule
`default_nettype wire

[design/tcs_back.sv]
`default_nettype none
`include "timed_counting_semaphore_core_assert.svh"
module tcs_back #(
	parameter int MAX_TIMED   = tcs_pkg::MAX_TIMED_DEF,
	parameter int MAX_UNTIMED = tcs_pkg::MAX_UNTIMED_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [tcs_pkg::INIT_W-1:0]  init_count,
	input  wire logic                        op_valid,
	output logic                             op_pop,
	input  wire tcs_pkg::op_t                op,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output logic [tcs_pkg::TASK_W-1:0]       res_task,
	output logic [tcs_pkg::OC_W-1:0]         res_outcome,
	output logic                             res_last
);
	localparam int TIW = (MAX_TIMED > 1) ? $clog2(MAX_TIMED) : 1;
	localparam int TSW = $clog2(MAX_TIMED + 1);
	localparam int UIW = (MAX_UNTIMED > 1) ? $clog2(MAX_UNTIMED) : 1;
	localparam int USW = $clog2(MAX_UNTIMED + 1);
	localparam int SUW = USW + 1;
	localparam int NXT = (MAX_TIMED > 1) ? 1 : 0;
	localparam logic [TSW-1:0] T_FULL = TSW'(MAX_TIMED);
	localparam logic [USW-1:0] U_FULL = USW'(MAX_UNTIMED);
	localparam logic [SUW-1:0] U_MOD  = SUW'(MAX_UNTIMED);
	localparam logic signed [tcs_pkg::COUNT_W-1:0] CNT_MAX = 16'sd32767;
	localparam logic signed [tcs_pkg::COUNT_W-1:0] CNT_MIN = -16'sd32768;

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXEC, ST_INS, ST_TICK, ST_FLUSH_T, ST_FLUSH_U
	} state_t;

	state_t                              state_q;
	tcs_pkg::op_t                        op_q;
	logic signed [tcs_pkg::COUNT_W-1:0]  count_q;
	logic [tcs_pkg::TASK_W-1:0]          t_task_q  [MAX_TIMED];
	logic [tcs_pkg::TIMEOUT_W-1:0]       t_delta_q [MAX_TIMED];
	logic [TSW-1:0]                      tsize_q;
	logic [tcs_pkg::TASK_W-1:0]          u_task_q  [MAX_UNTIMED];
	logic [UIW-1:0]                      uhead_q;
	logic [USW-1:0]                      usize_q;
	logic [TIW-1:0]                      idx_q;
	logic [tcs_pkg::TIMEOUT_W-1:0]       rem_q;
	logic                                out_valid_q, out_last_q;
	logic [tcs_pkg::TASK_W-1:0]          out_task_q;
	logic [tcs_pkg::OC_W-1:0]            out_oc_q;

	logic                                out_free;
	logic [TSW-1:0]                      tsize_m1;
	logic [TIW-1:0]                      t_rd_idx;
	logic [tcs_pkg::TASK_W-1:0]          t_rd_task;
	logic [tcs_pkg::TIMEOUT_W-1:0]       t_rd_delta;
	logic [SUW-1:0]                      u_wr_sum, u_tail_sum, u_head_inc;
	logic [UIW-1:0]                      u_wr_idx, u_tail_idx, u_rd_idx;
	logic [tcs_pkg::TASK_W-1:0]          u_rd_task;
	logic signed [tcs_pkg::COUNT_W-1:0]  cnt_inc, cnt_dec;
	logic                                walk_more;

	assign out_free    = !out_valid_q || res_ready;
	assign res_valid   = out_valid_q;
	assign res_task    = out_task_q;
	assign res_outcome = out_oc_q;
	assign res_last    = out_last_q;
	assign op_pop      = (state_q == ST_IDLE);

	assign tsize_m1   = tsize_q - TSW'(1);
	assign t_rd_idx   = (state_q == ST_INS) ? idx_q : tsize_m1[TIW-1:0];
	assign t_rd_task  = t_task_q[t_rd_idx];
	assign t_rd_delta = t_delta_q[t_rd_idx];
	assign walk_more  = (TSW'(idx_q) < tsize_q) && (rem_q >= t_rd_delta);

	always_comb begin
		u_wr_sum   = SUW'(uhead_q) + SUW'(usize_q);
		u_tail_sum = u_wr_sum - SUW'(1);
		u_head_inc = SUW'(uhead_q) + SUW'(1);
		if (u_wr_sum >= U_MOD) u_wr_sum = u_wr_sum - U_MOD;
		if (u_tail_sum >= U_MOD) u_tail_sum = u_tail_sum - U_MOD;
		if (u_head_inc >= U_MOD) u_head_inc = u_head_inc - U_MOD;
		u_wr_idx   = u_wr_sum[UIW-1:0];
		u_tail_idx = u_tail_sum[UIW-1:0];
		u_rd_idx   = (state_q == ST_FLUSH_U) ? u_tail_idx : uhead_q;
	end
	assign u_rd_task = u_task_q[u_rd_idx];

	assign cnt_inc = (count_q == CNT_MAX) ? count_q : count_q + 16'sd1;
	assign cnt_dec = (count_q == CNT_MIN) ? count_q : count_q - 16'sd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= {1'b0, tcs_pkg::INIT_COUNT_RST};
			tsize_q     <= '0;
			uhead_q     <= '0;
			usize_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (op_valid) begin
						op_q    <= op;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						out_last_q <= 1'b1;
						out_task_q <= op_q.task_id;
						state_q    <= ST_IDLE;
						unique case (op_q.func)
							tcs_pkg::FUNC_WAIT: begin
								out_valid_q <= 1'b1;
								if (count_q > 16'sd0) begin
									count_q  <= cnt_dec;
									out_oc_q <= tcs_pkg::OC_GRANTED;
								end else if (op_q.timeout != '0) begin
									if (tsize_q == T_FULL) begin
										out_oc_q <= tcs_pkg::OC_REFUSED;
									end else begin
										// result goes out once the slot is found
										out_valid_q <= 1'b0;
										idx_q       <= '0;
										rem_q       <= op_q.timeout;
										state_q     <= ST_INS;
									end
								end else if (usize_q == U_FULL) begin
									out_oc_q <= tcs_pkg::OC_REFUSED;
								end else begin
									u_task_q[u_wr_idx] <= op_q.task_id;
									usize_q            <= usize_q + USW'(1);
									count_q            <= cnt_dec;
									out_oc_q           <= tcs_pkg::OC_BLOCKED;
								end
							end
							tcs_pkg::FUNC_SIGNAL: begin
								out_valid_q <= 1'b1;
								count_q     <= cnt_inc;
								if (cnt_inc <= 16'sd0 && usize_q != '0) begin
									out_task_q <= u_rd_task;
									out_oc_q   <= tcs_pkg::OC_WOKEN;
									uhead_q    <= u_head_inc[UIW-1:0];
									usize_q    <= usize_q - USW'(1);
								end else if (cnt_inc <= 16'sd0 && tsize_q != '0) begin
									out_task_q <= t_rd_task;
									out_oc_q   <= tcs_pkg::OC_WOKEN;
									tsize_q    <= tsize_m1;
								end else begin
									out_task_q <= '0;
									out_oc_q   <= tcs_pkg::OC_NONE;
								end
							end
							tcs_pkg::FUNC_TICK: begin
								if (tsize_q != '0 && t_delta_q[0] <= 16'd1) begin
									t_delta_q[0] <= '0;
									state_q      <= ST_TICK;
								end else begin
									if (tsize_q != '0) t_delta_q[0] <= t_delta_q[0] - 16'd1;
									out_valid_q <= 1'b1;
									out_task_q  <= '0;
									out_oc_q    <= tcs_pkg::OC_NONE;
								end
							end
							tcs_pkg::FUNC_FLUSH: begin
								if (tsize_q != '0) begin
									state_q <= ST_FLUSH_T;
								end else if (usize_q != '0) begin
									state_q <= ST_FLUSH_U;
								end else begin
									out_valid_q <= 1'b1;
									out_task_q  <= '0;
									out_oc_q    <= tcs_pkg::OC_NONE;
									count_q     <= {1'b0, init_count};
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_INS: begin
					if (walk_more) begin
						rem_q <= rem_q - t_rd_delta;
						idx_q <= idx_q + TIW'(1);
					end else if (out_free) begin
						// open a hole at the walk index and shift the rest back
						for (int j = 1; j < MAX_TIMED; j++) begin
							if (TIW'(j) > idx_q && TSW'(j) <= tsize_q) begin
								t_task_q[j]  <= t_task_q[j-1];
								t_delta_q[j] <= t_delta_q[j-1];
							end
						end
						if (TSW'(idx_q) < tsize_q) t_delta_q[idx_q + TIW'(1)] <= t_rd_delta - rem_q;
						t_task_q[idx_q]  <= op_q.task_id;
						t_delta_q[idx_q] <= rem_q;
						tsize_q          <= tsize_q + TSW'(1);
						count_q          <= cnt_dec;
						out_valid_q      <= 1'b1;
						out_task_q       <= op_q.task_id;
						out_oc_q         <= tcs_pkg::OC_BLOCKED;
						out_last_q       <= 1'b1;
						state_q          <= ST_IDLE;
					end
				end
				ST_TICK: begin
					if (out_free) begin
						for (int j = 1; j < MAX_TIMED; j++) begin
							t_task_q[j-1]  <= t_task_q[j];
							t_delta_q[j-1] <= t_delta_q[j];
						end
						tsize_q     <= tsize_m1;
						count_q     <= cnt_inc;
						out_valid_q <= 1'b1;
						out_task_q  <= t_task_q[0];
						out_oc_q    <= tcs_pkg::OC_TIMEOUT;
						if (tsize_q > TSW'(1) && t_delta_q[NXT] == '0) begin
							out_last_q <= 1'b0;
						end else begin
							out_last_q <= 1'b1;
							state_q    <= ST_IDLE;
						end
					end
				end
				ST_FLUSH_T: begin
					if (out_free) begin
						tsize_q     <= tsize_m1;
						out_valid_q <= 1'b1;
						out_task_q  <= t_rd_task;
						out_oc_q    <= tcs_pkg::OC_FLUSHED;
						out_last_q  <= 1'b0;
						if (tsize_q == TSW'(1)) begin
							if (usize_q == '0) begin
								out_last_q <= 1'b1;
								count_q    <= {1'b0, init_count};
								state_q    <= ST_IDLE;
							end else begin
								state_q <= ST_FLUSH_U;
							end
						end
					end
				end
				ST_FLUSH_U: begin
					if (out_free) begin
						usize_q     <= usize_q - USW'(1);
						out_valid_q <= 1'b1;
						out_task_q  <= u_rd_task;
						out_oc_q    <= tcs_pkg::OC_FLUSHED;
						out_last_q  <= 1'b0;
						if (usize_q == USW'(1)) begin
							out_last_q <= 1'b1;
							count_q    <= {1'b0, init_count};
							state_q    <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`TCS_ASSERT_IMPL(a_tsize_bound, 1'b1, tsize_q <= T_FULL)
	`TCS_ASSERT_IMPL(a_usize_bound, 1'b1, usize_q <= U_FULL)
	`TCS_ASSERT_IMPL(a_flush_t_nonempty, state_q == ST_FLUSH_T, tsize_q != '0)
	`TCS_ASSERT_NEXT(a_exec_once, state_q == ST_EXEC && out_free, state_q != ST_EXEC)
endmodule
`default_nettype wire
